/* sv/stp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg
// Types, codes and the per-character transition function of the spectral
// type string parser.
// ----------------------------------------------------------------------------
package stp_pkg;

  typedef enum logic [4:0] {
    PH_BEGIN      = 5'd0,
    PH_END        = 5'd1,
    PH_WR_TYPE    = 5'd2,
    PH_CLASS      = 5'd3,
    PH_SUB        = 5'd4,
    PH_SUB_DEC    = 5'd5,
    PH_SUB_FINAL  = 5'd6,
    PH_LUM_BEGIN  = 5'd7,
    PH_LUM_I      = 5'd8,
    PH_LUM_II     = 5'd9,
    PH_LUM_V      = 5'd10,
    PH_LUM_IDASH  = 5'd11,
    PH_LUM_IA     = 5'd12,
    PH_LUM_IDASHA = 5'd13,
    PH_WD_TYPE    = 5'd14,
    PH_WD_EXT     = 5'd15,
    PH_WD_SUB     = 5'd16,
    PH_SUBDWARF   = 5'd17
  } phase_t;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_WHITE   = 2'd1;
  localparam logic [1:0] ST_NEUTRON = 2'd2;
  localparam logic [1:0] ST_BLACK   = 2'd3;

  localparam logic [4:0] CLS_O       = 5'd0;
  localparam logic [4:0] CLS_B       = 5'd1;
  localparam logic [4:0] CLS_A       = 5'd2;
  localparam logic [4:0] CLS_F       = 5'd3;
  localparam logic [4:0] CLS_G       = 5'd4;
  localparam logic [4:0] CLS_K       = 5'd5;
  localparam logic [4:0] CLS_M       = 5'd6;
  localparam logic [4:0] CLS_R       = 5'd7;
  localparam logic [4:0] CLS_S       = 5'd8;
  localparam logic [4:0] CLS_N       = 5'd9;
  localparam logic [4:0] CLS_WC      = 5'd10;
  localparam logic [4:0] CLS_WN      = 5'd11;
  localparam logic [4:0] CLS_WO      = 5'd12;
  localparam logic [4:0] CLS_UNKNOWN = 5'd13;
  localparam logic [4:0] CLS_L       = 5'd14;
  localparam logic [4:0] CLS_T       = 5'd15;
  localparam logic [4:0] CLS_Y       = 5'd16;
  localparam logic [4:0] CLS_C       = 5'd17;
  localparam logic [4:0] CLS_DA      = 5'd18;
  localparam logic [4:0] CLS_DB      = 5'd19;
  localparam logic [4:0] CLS_DC      = 5'd20;
  localparam logic [4:0] CLS_DO      = 5'd21;
  localparam logic [4:0] CLS_DQ      = 5'd22;
  localparam logic [4:0] CLS_DZ      = 5'd23;
  localparam logic [4:0] CLS_D       = 5'd24;
  localparam logic [4:0] CLS_DX      = 5'd25;

  localparam logic [3:0] DIG_UNKNOWN = 4'd10;

  localparam logic [3:0] LUM_IA0     = 4'd0;
  localparam logic [3:0] LUM_IA      = 4'd1;
  localparam logic [3:0] LUM_IB      = 4'd2;
  localparam logic [3:0] LUM_II      = 4'd3;
  localparam logic [3:0] LUM_III     = 4'd4;
  localparam logic [3:0] LUM_IV      = 4'd5;
  localparam logic [3:0] LUM_V       = 4'd6;
  localparam logic [3:0] LUM_VI      = 4'd7;
  localparam logic [3:0] LUM_UNSET   = 4'd8;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] star;
    logic [4:0] cls;
    logic [3:0] dig;
    logic [3:0] lum;
  } stp_state_t;

  typedef struct packed {
    stp_state_t st;
    logic       consumed;
  } stp_trans_t;

  typedef struct packed {
    logic [1:0] star_type;
    logic [4:0] spectral_class;
    logic [3:0] subclass_digit;
    logic [3:0] luminosity_class;
  } stp_result_t;

  localparam stp_state_t STATE_RESET = '{
    phase: PH_BEGIN,
    star:  ST_NORMAL,
    cls:   CLS_UNKNOWN,
    dig:   DIG_UNKNOWN,
    lum:   LUM_UNSET
  };

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // {ok, class}
  function automatic logic [5:0] normal_class(input logic [7:0] c);
    logic [5:0] r;
    case (c)
      "O":     r = {1'b1, CLS_O};
      "B":     r = {1'b1, CLS_B};
      "A":     r = {1'b1, CLS_A};
      "F":     r = {1'b1, CLS_F};
      "G":     r = {1'b1, CLS_G};
      "K":     r = {1'b1, CLS_K};
      "M":     r = {1'b1, CLS_M};
      "R":     r = {1'b1, CLS_R};
      "S":     r = {1'b1, CLS_S};
      "N":     r = {1'b1, CLS_N};
      "L":     r = {1'b1, CLS_L};
      "T":     r = {1'b1, CLS_T};
      "Y":     r = {1'b1, CLS_Y};
      "C":     r = {1'b1, CLS_C};
      default: r = {1'b0, CLS_O};
    endcase
    return r;
  endfunction

  // One state machine transition; consumed is low when the character must be
  // offered again to the new phase.
  function automatic stp_trans_t stp_trans(input stp_state_t s, input logic [7:0] c);
    stp_trans_t r;
    logic [5:0] nc;
    r.st       = s;
    r.consumed = 1'b1;
    nc         = normal_class(c);
    case (s.phase)
      PH_BEGIN: begin
        if (c == "Q") begin
          r.st.star = ST_NEUTRON; r.st.phase = PH_END; r.consumed = 1'b0;
        end else if (c == "X") begin
          r.st.star = ST_BLACK; r.st.phase = PH_END; r.consumed = 1'b0;
        end else if (c == "D") begin
          r.st.star = ST_WHITE; r.st.cls = CLS_D; r.st.phase = PH_WD_TYPE;
        end else if (c == "s") begin
          r.st.phase = PH_SUBDWARF;
        end else if (c == CH_QMARK) begin
          r.st.phase = PH_END; r.consumed = 1'b0;
        end else begin
          r.st.phase = PH_CLASS; r.consumed = 1'b0;
        end
      end
      PH_WR_TYPE: begin
        r.st.phase = PH_SUB;
        if (c == "C") r.st.cls = CLS_WC;
        else if (c == "N") r.st.cls = CLS_WN;
        else if (c == "O") r.st.cls = CLS_WO;
        else begin
          r.st.cls = CLS_WC; r.consumed = 1'b0;
        end
      end
      PH_SUBDWARF: begin
        if (c == "d") begin
          r.st.lum = LUM_VI; r.st.phase = PH_CLASS;
        end else begin
          r.st.phase = PH_END; r.consumed = 1'b0;
        end
      end
      PH_CLASS: begin
        if (c == "W") r.st.phase = PH_WR_TYPE;
        else if (nc[5]) begin
          r.st.cls = nc[4:0]; r.st.phase = PH_SUB;
        end else r.st.phase = PH_END;
      end
      PH_SUB: begin
        if (is_digit(c)) begin
          r.st.dig = c[3:0]; r.st.phase = PH_SUB_DEC;
        end else begin
          r.st.phase = PH_LUM_BEGIN; r.consumed = 1'b0;
        end
      end
      PH_SUB_DEC: begin
        if (c == CH_DOT) r.st.phase = PH_SUB_FINAL;
        else begin
          r.st.phase = PH_LUM_BEGIN; r.consumed = 1'b0;
        end
      end
      PH_SUB_FINAL: r.st.phase = is_digit(c) ? PH_LUM_BEGIN : PH_END;
      PH_LUM_BEGIN: begin
        if (c == "I") r.st.phase = PH_LUM_I;
        else if (c == "V") r.st.phase = PH_LUM_V;
        else if (c != CH_SPACE) r.st.phase = PH_END;
      end
      PH_LUM_I: begin
        if (c == "I") r.st.phase = PH_LUM_II;
        else if (c == "V") begin
          r.st.lum = LUM_IV; r.st.phase = PH_END;
        end else if (c == "a") r.st.phase = PH_LUM_IA;
        else if (c == CH_DASH) r.st.phase = PH_LUM_IDASH;
        else begin
          r.st.lum = LUM_IB; r.st.phase = PH_END;
        end
      end
      PH_LUM_II: begin
        r.st.lum = (c == "I") ? LUM_III : LUM_II;
        r.st.phase = PH_END; r.consumed = 1'b0;
      end
      PH_LUM_IDASH: begin
        if (c == "a") r.st.phase = PH_LUM_IDASHA;
        else begin
          r.st.lum = LUM_IB; r.st.phase = PH_END; r.consumed = 1'b0;
        end
      end
      PH_LUM_IA: begin
        if (c == CH_DASH) r.st.phase = PH_LUM_IDASHA;
        else begin
          r.st.lum = (c == CH_ZERO) ? LUM_IA0 : LUM_IA;
          r.st.phase = PH_END; r.consumed = 1'b0;
        end
      end
      PH_LUM_IDASHA: begin
        r.st.lum = (c == CH_ZERO) ? LUM_IA0 : LUM_IA;
        r.st.phase = PH_END; r.consumed = 1'b0;
      end
      PH_LUM_V: begin
        r.st.lum = (c == "I") ? LUM_VI : LUM_V;
        r.st.phase = PH_END; r.consumed = 1'b0;
      end
      PH_WD_TYPE: begin
        r.st.phase = PH_WD_EXT;
        case (c)
          "A":     r.st.cls = CLS_DA;
          "B":     r.st.cls = CLS_DB;
          "C":     r.st.cls = CLS_DC;
          "O":     r.st.cls = CLS_DO;
          "Q":     r.st.cls = CLS_DQ;
          "Z":     r.st.cls = CLS_DZ;
          "X":     r.st.cls = CLS_DX;
          default: begin
            r.st.cls = CLS_D; r.consumed = 1'b0;
          end
        endcase
      end
      PH_WD_EXT: begin
        if (!(c inside {"A", "B", "C", "O", "Q", "Z", "X", "V", "P", "H", "E"})) begin
          r.st.phase = PH_WD_SUB; r.consumed = 1'b0;
        end
      end
      PH_WD_SUB: begin
        r.st.phase = PH_END;
        if (is_digit(c)) r.st.dig = c[3:0];
        else r.consumed = 1'b0;
      end
      default: begin
        r.st.phase = PH_END; r.consumed = 1'b0;
      end
    endcase
    return r;
  endfunction

endpackage

/* sv/stp_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_in_stage
// Input register for the character channel.
// ----------------------------------------------------------------------------
module stp_in_stage import stp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  input  logic       advance,
  output logic       s1_vld,
  output logic [7:0] s1_ch
);

  logic       vld_r;
  logic       vld_nxt;
  logic [7:0] ch_r;
  logic       take;

  assign in_stall = vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    if (take) vld_nxt = 1'b1;
    else if (advance) vld_nxt = 1'b0;
    else vld_nxt = vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (take) ch_r <= in_ch;
  end

  assign s1_vld = vld_r;
  assign s1_ch  = ch_r;

endmodule

/* sv/stp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_parser
// Parse state register and the folded per-character transitions.
// ----------------------------------------------------------------------------
module stp_parser import stp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  ch,
  output stp_result_t res
);

  stp_state_t st_r;
  stp_state_t st_nxt;
  stp_trans_t t0;
  stp_trans_t t1;
  stp_trans_t t2;
  stp_state_t fed;

  // at most three transitions per character
  always_comb begin
    t0 = stp_trans(st_r, ch);
    t1 = stp_trans(t0.st, ch);
    t2 = stp_trans(t1.st, ch);
    if (st_r.phase == PH_END || t0.consumed) fed = t0.st;
    else if (t0.st.phase == PH_END || t1.consumed) fed = t1.st;
    else fed = t2.st;
  end

  always_comb begin
    if (!fire) st_nxt = st_r;
    else if (ch == CH_NUL) st_nxt = STATE_RESET;
    else st_nxt = fed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= STATE_RESET;
    else st_r <= st_nxt;
  end

  assign res.star_type        = fed.star;
  assign res.spectral_class   = fed.cls;
  assign res.subclass_digit   = fed.dig;
  assign res.luminosity_class = fed.lum;

  a_term_resets: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ch == CH_NUL |=> st_r == STATE_RESET)
    else $error("parse state not cleared after terminator");

  a_end_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && ch != CH_NUL && st_r.phase == PH_END |=> $stable(st_r))
    else $error("state changed after parse finished");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(st_r))
    else $error("state changed without a character");

endmodule

/* sv/stp_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_out_stage
// Result register for the parsed spectral type fields.
// ----------------------------------------------------------------------------
module stp_out_stage import stp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  stp_result_t res,
  output logic        can_load,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_star_type,
  output logic [4:0]  out_spectral_class,
  output logic [3:0]  out_subclass_digit,
  output logic [3:0]  out_luminosity_class
);

  logic        vld_r;
  logic        vld_nxt;
  stp_result_t res_r;

  assign can_load = !vld_r || !out_stall;

  always_comb begin
    if (push) vld_nxt = 1'b1;
    else if (out_stall) vld_nxt = vld_r;
    else vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

  always_ff @(posedge clk) begin
    if (push) res_r <= res;
  end

  assign out_valid            = vld_r;
  assign out_star_type        = res_r.star_type;
  assign out_spectral_class   = res_r.spectral_class;
  assign out_subclass_digit   = res_r.subclass_digit;
  assign out_luminosity_class = res_r.luminosity_class;

endmodule

/* sv/spectral_type_string_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectral_type_string_parser_top
// Parses a stellar spectral type string, one character per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_ch) carries one character per
//   transaction; a zero character ends the string. Output channel
//   (out_valid / out_stall / out_*) carries one transaction per string:
//   star type, spectral class, subclass digit and luminosity class.
//   A character is taken every cycle while in_stall is low. Each character
//   passes an input register and then updates the parse state; for the
//   terminator the fields land in the result register in that same update,
//   so out_valid rises once the terminator has left the input register.
//   While a result waits under out_stall, ordinary characters keep flowing;
//   only a further terminator holds in the input register and raises
//   in_stall until the result register frees.
//   Reset (rst_n low, synchronous) empties both registers and returns the
//   parse state to begin with all fields unknown.
// ----------------------------------------------------------------------------
module spectral_type_string_parser_top import stp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_star_type,
  output logic [4:0] out_spectral_class,
  output logic [3:0] out_subclass_digit,
  output logic [3:0] out_luminosity_class
);

  logic        s1_vld;
  logic [7:0]  s1_ch;
  logic        can_load;
  logic        is_term;
  logic        advance;
  logic        fire;
  stp_result_t res;

  assign is_term = s1_ch == CH_NUL;
  assign advance = !is_term || can_load;
  assign fire    = s1_vld && advance;

  stp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .advance  (advance),
    .s1_vld   (s1_vld),
    .s1_ch    (s1_ch)
  );

  stp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ch    (s1_ch),
    .res   (res)
  );

  stp_out_stage u_out (
    .clk                  (clk),
    .rst_n                (rst_n),
    .push                 (fire && is_term),
    .res                  (res),
    .can_load             (can_load),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_star_type        (out_star_type),
    .out_spectral_class   (out_spectral_class),
    .out_subclass_digit   (out_subclass_digit),
    .out_luminosity_class (out_luminosity_class)
  );

  a_rise_after_term: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_vld && is_term && can_load))
    else $error("result without terminator");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld && is_term && out_valid && out_stall)
    else $error("input stalled without a blocked terminator");

  a_compact_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_star_type == ST_NEUTRON || out_star_type == ST_BLACK)
    |-> out_spectral_class == CLS_UNKNOWN && out_subclass_digit == DIG_UNKNOWN &&
        out_luminosity_class == LUM_UNSET)
    else $error("compact object carries class fields");

endmodule
